// File: rtl/core/pal_pkg.sv
// Shared types and constants for the palindromic subsequence length block.
package pal_pkg;

  localparam int CHAR_W    = 8;  // width of one string byte
  localparam int LPS_W     = 7;  // width of the reported length field
  localparam int PAIR_GAIN = 2;  // length added by a matching outer pair

  // Release of a string buffer bank by the back end once its result is taken.
  typedef struct packed {
    logic done;
    logic bank;
  } bank_rel_t;

endpackage

// File: rtl/core/pal_if.sv
// Valid/ready channel interfaces for string bytes and length results.
interface pal_in_if;
  logic                       valid;
  logic                       ready;
  logic [pal_pkg::CHAR_W-1:0] char_in;
  logic                       last;

  modport source (output valid, output char_in, output last, input ready);
  modport sink   (input valid, input char_in, input last, output ready);
endinterface

interface pal_out_if;
  logic                      valid;
  logic                      ready;
  logic [pal_pkg::LPS_W-1:0] lps_length;
  logic                      truncated;

  modport source (output valid, output lps_length, output truncated, input ready);
  modport sink   (input valid, input lps_length, input truncated, output ready);
endinterface

// File: rtl/core/palindromic_subsequence_length_top.sv
// Top level of the longest palindromic subsequence length block.
//
// Bytes of a string arrive one per request on in_ch, the final byte marked by
// last; one result per string leaves on out_ch with the length of the longest
// palindromic subsequence and a truncated flag. At most MAX_LEN bytes are kept;
// later bytes of the same string are dropped and flag the result. The front
// end fills one of two buffer banks and queues a job per string, so the next
// string loads while the back end evaluates the previous one. The back end
// sweeps the interval table row by row, one cell per cycle within a row,
// against a single rolling row memory. The front end holds off new bytes
// only while both banks wait on the back end.
module palindromic_subsequence_length_top #(
  parameter int MAX_LEN = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  pal_in_if.sink    in_ch,
  pal_out_if.source out_ch
);
  import pal_pkg::*;

  localparam int AW = $clog2(MAX_LEN);      // index into one bank
  localparam int CW = $clog2(MAX_LEN + 1);  // byte count, holds MAX_LEN itself
  localparam int LW = $clog2(MAX_LEN + 1);  // DP cell width
  localparam int JW = CW + 2;               // job word: bank, overflow, count

  logic              mem_we;
  logic [AW:0]       mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic              job_push, job_space, job_pop, job_avail;
  logic [JW-1:0]     job_in, job_out;
  bank_rel_t         rel;
  logic [LW-1:0]     res_len;
  logic [LW+LPS_W-1:0] res_ext;

  // Front end: accept bytes, fill the open bank, post a job on the last byte.
  pal_front #(.MAX_LEN(MAX_LEN), .AW(AW), .CW(CW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_char   (in_ch.char_in),
    .in_last   (in_ch.last),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .job_push  (job_push),
    .job_data  (job_in),
    .job_space (job_space),
    .rel       (rel)
  );

  // Hold finished strings until the back end is free.
  pal_queue #(.W(JW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .space     (job_space),
    .pop       (job_pop),
    .avail     (job_avail),
    .pop_data  (job_out)
  );

  // Back end: evaluate one string at a time and present the result.
  pal_back #(.MAX_LEN(MAX_LEN), .AW(AW), .CW(CW), .LW(LW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .job_avail (job_avail),
    .job_data  (job_out),
    .job_pop   (job_pop),
    .rel       (rel),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res_len   (res_len),
    .res_trunc (out_ch.truncated)
  );

  // Fit the DP width to the 7-bit length field, dropping high bits if wider.
  assign res_ext           = {{LPS_W{1'b0}}, res_len};
  assign out_ch.lps_length = res_ext[LPS_W-1:0];

endmodule

// File: rtl/core/pal_front.sv
// Front end: store string bytes into a free buffer bank and post a job on the last byte.
module pal_front #(
  parameter int MAX_LEN = 64,
  parameter int AW      = 6,
  parameter int CW      = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pal_pkg::CHAR_W-1:0] in_char,
  input  logic                       in_last,
  output logic                       mem_we,
  output logic [AW:0]                mem_waddr,
  output logic [pal_pkg::CHAR_W-1:0] mem_wdata,
  output logic                       job_push,
  output logic [CW+1:0]              job_data,
  input  logic                       job_space,
  input  pal_pkg::bank_rel_t         rel
);
  import pal_pkg::*;

  logic          wbank_r, wbank_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [1:0]    busy_r, busy_nxt;
  logic          acc, has_room;
  logic [CW-1:0] cnt_after;
  logic          ovf_after;

  assign in_ready  = !busy_r[wbank_r] && job_space;
  assign acc       = in_valid && in_ready;
  assign has_room  = cnt_r < CW'(MAX_LEN);
  assign cnt_after = has_room ? cnt_r + CW'(1) : cnt_r;
  assign ovf_after = ovf_r || !has_room;

  assign mem_we    = acc && has_room;
  assign mem_waddr = {wbank_r, cnt_r[AW-1:0]};
  assign mem_wdata = in_char;

  // Job word: bank, overflow flag, stored byte count.
  assign job_push  = acc && in_last;
  assign job_data  = {wbank_r, ovf_after, cnt_after};

  always_comb begin
    wbank_nxt = wbank_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    busy_nxt  = busy_r;
    if (rel.done) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (acc) begin
      if (in_last) begin
        cnt_nxt            = '0;
        ovf_nxt            = 1'b0;
        busy_nxt[wbank_r]  = 1'b1;
        wbank_nxt          = !wbank_r;
      end else begin
        cnt_nxt = cnt_after;
        ovf_nxt = ovf_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wbank_r <= 1'b0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      busy_r  <= '0;
    end else begin
      wbank_r <= wbank_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

// File: rtl/core/pal_queue.sv
// Two-entry job queue between the front end and the back end.
module pal_queue #(
  parameter int W = 9
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         space,
  input  logic         pop,
  output logic         avail,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] entry_r [0:1];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign space    = cnt_r != 2'd2;
  assign avail    = cnt_r != 2'd0;
  assign pop_data = entry_r[rp_r];
  assign do_push  = push && space;
  assign do_pop   = pop && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// File: rtl/core/pal_back.sv
// Back end: byte buffer, rolling DP row, interval sweep, one cell per cycle in a row.
module pal_back #(
  parameter int MAX_LEN = 64,
  parameter int AW      = 6,
  parameter int CW      = 7,
  parameter int LW      = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       mem_we,
  input  logic [AW:0]                mem_waddr,
  input  logic [pal_pkg::CHAR_W-1:0] mem_wdata,
  input  logic                       job_avail,
  input  logic [CW+1:0]              job_data,
  output logic                       job_pop,
  output pal_pkg::bank_rel_t         rel,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [LW-1:0]              res_len,
  output logic                       res_trunc
);
  import pal_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ROW, S_STEP, S_OUT} state_t;

  logic [CHAR_W-1:0] cmem [0:(1 << (AW + 1)) - 1];
  logic [LW-1:0]     rmem [0:(1 << AW) - 1];

  state_t        state_r;
  logic          bank_r, ovf_r;
  logic [CW-1:0] n_r;
  logic [AW-1:0] i_r, j_r;
  logic [LW-1:0] diag_r, left_r, res_r;
  logic [CHAR_W-1:0] ca_r, cb_r;
  logic [LW-1:0] rr_r;

  logic [AW-1:0] rd_idx;
  logic          job_bank, job_ovf;
  logic [CW-1:0] job_n;
  logic          eq, adj, row_end;
  logic [LW-1:0] nv, mx, rr_eff;
  logic          row_we;

  assign {job_bank, job_ovf, job_n} = job_data;
  assign job_pop   = (state_r == S_IDLE) && job_avail;
  assign res_valid = (state_r == S_OUT);
  assign res_len   = res_r;
  assign res_trunc = ovf_r;
  assign rel.done  = res_valid && res_ready;
  assign rel.bank  = bank_r;

  // Column read index: first column of a row, else the next column.
  assign rd_idx  = (state_r == S_ROW) ? i_r + AW'(1) : j_r + AW'(1);

  // The diagonal cell of the row below is always one and is never stored.
  assign rr_eff  = adj ? LW'(1) : rr_r;

  assign eq      = ca_r == cb_r;
  assign adj     = j_r == i_r + AW'(1);
  assign mx      = (left_r > rr_eff) ? left_r : rr_eff;
  assign nv      = eq ? (adj ? LW'(PAIR_GAIN) : diag_r + LW'(PAIR_GAIN)) : mx;
  assign row_end = j_r == AW'(n_r - CW'(1));
  assign row_we  = (state_r == S_STEP);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cmem[mem_waddr] <= mem_wdata;
    end
    ca_r <= cmem[{bank_r, i_r}];
    cb_r <= cmem[{bank_r, rd_idx}];
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      rmem[j_r] <= nv;
    end
    rr_r <= rmem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (job_avail) begin
            bank_r <= job_bank;
            ovf_r  <= job_ovf;
            n_r    <= job_n;
            if (job_n == CW'(1)) begin
              res_r   <= LW'(1);
              state_r <= S_OUT;
            end else begin
              i_r     <= AW'(job_n - CW'(2));
              state_r <= S_ROW;
            end
          end
        end
        S_ROW: begin
          j_r     <= i_r + AW'(1);
          left_r  <= LW'(1);
          state_r <= S_STEP;
        end
        S_STEP: begin
          diag_r <= rr_eff;
          left_r <= nv;
          if (row_end) begin
            if (i_r == '0) begin
              res_r   <= nv;
              state_r <= S_OUT;
            end else begin
              i_r     <= i_r - AW'(1);
              state_r <= S_ROW;
            end
          end else begin
            j_r <= j_r + AW'(1);
          end
        end
        S_OUT: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/pal_checker.sv
// Port-level checks for the palindromic subsequence length block, bound to the top level.
module pal_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // Hold a result until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // Drop any result on reset.
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // Both banks are free after reset, so bytes are taken at once.
  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // The back end returns to pickup after a result, so results never abut.
  a_res_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("results presented back to back");

endmodule

bind palindromic_subsequence_length_top pal_checker u_pal_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
